// ----- hw/rtl/gcb_pkg.sv -----
// package: types, constants and arctangent table for the bearing pipeline
package gcb_pkg;

  localparam int AtanEntries = 31;
  localparam int RotW = 34;
  localparam int VecW = 36;
  localparam logic signed [RotW-1:0] InvGain = 34'sh026DD3B6A;
  localparam logic signed [RotW-1:0] QuarterTurn = 34'sh040000000;
  localparam logic signed [RotW-1:0] HalfTurn = 34'sh080000000;

  // rotation-mode cordic state
  typedef struct packed {
    logic signed [RotW-1:0] x;
    logic signed [RotW-1:0] y;
    logic signed [RotW-1:0] z;
  } rot_t;

  // vectoring-mode cordic state
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [31:0] z;
  } vec_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517; 5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145; 5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/great_circle_bearing.sv -----
// top level: pipelined great-circle initial bearing
// registers in order: fold, rotation, product, vectoring, output
// throughput: one position pair per cycle; the whole pipeline holds while the
// output register is full and not taken
// reset: rst clears all valid bits; payload registers are not reset
module great_circle_bearing #(
  parameter int CORDIC_STAGES = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // from_lat, from_lon, to_lat, to_lon
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata   // bearing
);
  import gcb_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // rotation pipeline, three lanes: from_lat, to_lat, dlon
  rot_t       rot [0:N][0:2];
  logic [2:0] flip [0:N];
  logic       rzero [0:N];
  logic       rv [0:N];

  logic [31:0] in_lat1, in_lat2, in_dlon;
  assign in_lat1 = s_axis_tdata[31:0];
  assign in_lat2 = s_axis_tdata[95:64];
  assign in_dlon = s_axis_tdata[127:96] - s_axis_tdata[63:32];

  // quadrant fold
  rot_t       fold [0:2];
  logic [2:0] fold_flip;
  always_comb begin
    logic signed [RotW-1:0] a [0:2];
    a[0] = RotW'(signed'(in_lat1));
    a[1] = RotW'(signed'(in_lat2));
    a[2] = RotW'(signed'(in_dlon));
    for (int j = 0; j < 3; j++) begin
      fold[j].x = InvGain;
      fold[j].y = '0;
      fold_flip[j] = 1'b1;
      if (a[j] > QuarterTurn) begin
        fold[j].z = a[j] - HalfTurn;
      end else if (a[j] < -QuarterTurn) begin
        fold[j].z = a[j] + HalfTurn;
      end else begin
        fold[j].z = a[j];
        fold_flip[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= s_axis_tvalid;
    end
    if (adv) begin
      for (int j = 0; j < 3; j++) rot[0][j] <= fold[j];
      flip[0] <= fold_flip;
      rzero[0] <= (in_lat1 == in_lat2) && (in_dlon == '0);
    end
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i+1] <= 1'b0;
      end else if (adv) begin
        rv[i+1] <= rv[i];
      end
      if (adv) begin
        for (int j = 0; j < 3; j++) begin
          if (rot[i][j].z >= 0) begin
            rot[i+1][j].x <= rot[i][j].x - (rot[i][j].y >>> i);
            rot[i+1][j].y <= rot[i][j].y + (rot[i][j].x >>> i);
            rot[i+1][j].z <= rot[i][j].z - RotW'(atan_lut(5'(i)));
          end else begin
            rot[i+1][j].x <= rot[i][j].x + (rot[i][j].y >>> i);
            rot[i+1][j].y <= rot[i][j].y - (rot[i][j].x >>> i);
            rot[i+1][j].z <= rot[i][j].z + RotW'(atan_lut(5'(i)));
          end
        end
        flip[i+1] <= flip[i];
        rzero[i+1] <= rzero[i];
      end
    end
  end

  // sin and cos after sign fix
  logic signed [31:0] s1, c1, s2, c2, sd, cd;
  always_comb begin
    s1 = flip[N][0] ? -rot[N][0].y[31:0] : rot[N][0].y[31:0];
    c1 = flip[N][0] ? -rot[N][0].x[31:0] : rot[N][0].x[31:0];
    s2 = flip[N][1] ? -rot[N][1].y[31:0] : rot[N][1].y[31:0];
    c2 = flip[N][1] ? -rot[N][1].x[31:0] : rot[N][1].x[31:0];
    sd = flip[N][2] ? -rot[N][2].y[31:0] : rot[N][2].y[31:0];
    cd = flip[N][2] ? -rot[N][2].x[31:0] : rot[N][2].x[31:0];
  end

  // product stages
  logic signed [63:0] p_a1, p_a2a, p_t;
  logic signed [31:0] m1_cd;
  logic signed [33:0] m2_a1, m2_a2a;
  logic signed [63:0] m2_q;
  logic signed [VecW-1:0] m3_a1, m3_a2;
  logic m1v, m2v, m3v, m1z, m2z, m3z;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
      m2v <= 1'b0;
      m3v <= 1'b0;
    end else if (adv) begin
      m1v <= rv[N];
      m2v <= m1v;
      m3v <= m2v;
    end
    if (adv) begin
      p_a1 <= 64'(sd) * 64'(c2);
      p_a2a <= 64'(c1) * 64'(s2);
      p_t <= 64'(s1) * 64'(c2);
      m1_cd <= cd;
      m1z <= rzero[N];
      m2_a1 <= 34'(p_a1 >>> 30);
      m2_a2a <= 34'(p_a2a >>> 30);
      m2_q <= 64'(signed'(p_t[63:30])) * 64'(m1_cd);
      m2z <= m1z;
      m3_a1 <= VecW'(m2_a1);
      m3_a2 <= VecW'(m2_a2a) - VecW'(m2_q >>> 30);
      m3z <= m2z;
    end
  end

  // vectoring pipeline
  vec_t vec [0:N];
  logic vz [0:N];
  logic vv [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (adv) begin
      vv[0] <= m3v;
    end
    if (adv) begin
      if (m3_a2 < 0) begin
        vec[0].x <= -m3_a2;
        vec[0].y <= -m3_a1;
        vec[0].z <= 32'h80000000;
      end else begin
        vec[0].x <= m3_a2;
        vec[0].y <= m3_a1;
        vec[0].z <= '0;
      end
      vz[0] <= m3z || (m3_a1 == '0 && m3_a2 == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else if (adv) begin
        vv[i+1] <= vv[i];
      end
      if (adv) begin
        if (vec[i].y >= 0) begin
          vec[i+1].x <= vec[i].x + (vec[i].y >>> i);
          vec[i+1].y <= vec[i].y - (vec[i].x >>> i);
          vec[i+1].z <= vec[i].z + atan_lut(5'(i));
        end else begin
          vec[i+1].x <= vec[i].x - (vec[i].y >>> i);
          vec[i+1].y <= vec[i].y + (vec[i].x >>> i);
          vec[i+1].z <= vec[i].z - atan_lut(5'(i));
        end
        vz[i+1] <= vz[i];
      end
    end
  end

  // rounding and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= vv[N];
    end
    if (adv) begin
      m_axis_tdata <= vz[N] ? 16'h0000 : vec[N].z[31:16] + 16'(vec[N].z[15]);
    end
  end

endmodule

// ----- hw/rtl/gcb_checker.sv -----
// checker: port-level properties of the bearing pipeline, bound to the top level
module gcb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [15:0]  m_axis_tdata
);

  // output cleared by reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // stalled output transfer holds its data
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  // a held result freezes the input side
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline held");

  // with the output free the input is always taken
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind great_circle_bearing gcb_checker u_gcb_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// ----- tb/great_circle_bearing_test.sv -----
// testbench: great-circle bearing pipeline against a fixed-point course predictor
`timescale 1ns / 100ps

// queue of predicted bearings and the comparison of delivered ones
class bearing_board;
  logic [15:0] pending[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  // note an accepted position pair by its predicted bearing
  function void note_pair(logic [15:0] b);
    pending.push_back(b);
  endfunction

  // compare a delivered bearing with the oldest prediction
  function void check_bearing(logic [15:0] got);
    logic [15:0] want;
    if (pending.size() == 0) begin
      $error("bearing: no prediction waiting, actual %0d", got);
      errors++;
    end else begin
      want = pending.pop_front();
      checked++;
      if (want !== got) begin
        $error("bearing: expected %0d actual %0d", want, got);
        errors++;
      end
    end
  endfunction
endclass

module great_circle_bearing_test;
  localparam int Stages = 18;
  localparam int Latency = 2 * Stages + 6;
  localparam int NumRandom = 1000;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  bearing_board board = new();
  longint cycles = 0;
  bit calm = 1'b0;
  bit hold_long = 1'b0;
  int sent = 0;

  great_circle_bearing #(.CORDIC_STAGES(Stages)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  // floor shift of a wide signed value
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // rotation cordic: sine and cosine of a binary angle, 1.0 = 2^30
  function automatic void angle_sincos(logic [31:0] ang, output longint s,
                                       output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ang));
    flip = 0;
    x = 64'h26DD3B6A;
    y = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < Stages && i < gcb_pkg::AtanEntries; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(gcb_pkg::atan_lut(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(gcb_pkg::atan_lut(5'(i)));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  // initial course from the first position to the second
  function automatic logic [15:0] course_of(logic [127:0] d);
    logic [31:0] lat1, lat2, dlon, z;
    longint s1, c1, s2, c2, sd, cd, a1, a2, dx, dy;
    lat1 = d[31:0];
    lat2 = d[95:64];
    dlon = d[127:96] - d[63:32];
    if (lat1 == lat2 && dlon == 0) return 16'd0;
    angle_sincos(lat1, s1, c1);
    angle_sincos(lat2, s2, c2);
    angle_sincos(dlon, sd, cd);
    a1 = shr_floor(sd * c2, 30);
    a2 = shr_floor(c1 * s2, 30) - shr_floor(shr_floor(s1 * c2, 30) * cd, 30);
    if (a1 == 0 && a2 == 0) return 16'd0;
    z = 32'd0;
    if (a2 < 0) begin
      a2 = -a2; a1 = -a1; z = 32'h80000000;
    end
    for (int i = 0; i < Stages && i < gcb_pkg::AtanEntries; i++) begin
      dx = shr_floor(a1, i);
      dy = shr_floor(a2, i);
      if (a1 >= 0) begin
        a2 += dx; a1 -= dy; z += gcb_pkg::atan_lut(5'(i));
      end else begin
        a2 -= dx; a1 += dy; z -= gcb_pkg::atan_lut(5'(i));
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  // random latitude, extremes included, within plus or minus a quarter turn, or at times any 32-bit angle
  function automatic logic [31:0] pick_lat();
    case ($urandom_range(0, 9))
      0: return 32'h40000000;
      1: return 32'hC0000000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h80000000) - 32'h40000000;
    endcase
  endfunction

  // offer one position pair and wait for its transfer
  task automatic send_pair(logic [31:0] lat1, logic [31:0] lon1,
                           logic [31:0] lat2, logic [31:0] lon2);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lon2, lat2, lon1, lat1};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_pair(course_of({lon2, lat2, lon1, lat1}));
    sent++;
  endtask

  // result side: random stalls, one long hold-off, and checking
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) board.check_bearing(m_axis_tdata);
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_long = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [31:0] lat1, lon1, lat2, lon2;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: coincident points, poles, wrap of longitude, cardinal courses
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF0);
    send_pair(32'h40000000, 32'h0, 32'h40000000, 32'h0);
    send_pair(32'h40000000, 32'h0, 32'h40000000, 32'h10000000);
    send_pair(32'hC0000000, 32'h0, 32'hC0000000, 32'h80000000);
    send_pair(32'h0, 32'h0, 32'h10000000, 32'h0);
    send_pair(32'h0, 32'h0, 32'hF0000000, 32'h0);
    send_pair(32'h0, 32'h0, 32'h0, 32'h10000000);
    send_pair(32'h0, 32'h0, 32'h0, 32'hF0000000);
    send_pair(32'h0, 32'h7FFFFFFF, 32'h0, 32'h80000000);
    send_pair(32'h0, 32'h80000000, 32'h0, 32'h7FFFFFFF);
    send_pair(32'h0, 32'h0, 32'h0, 32'h80000000);
    send_pair(32'h40000000, 32'h0, 32'hC0000000, 32'h0);
    send_pair(32'hC0000000, 32'h7FFFFFFF, 32'h40000000, 32'h80000000);
    send_pair(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h00000001);
    send_pair(32'hFFFFFFFF, 32'h0, 32'h1, 32'h0);
    send_pair(32'h20000000, 32'h0, 32'hE0000000, 32'h40000000);
    send_pair(32'h3FFFFFFF, 32'h55555555, 32'hC0000001, 32'hAAAAAAAA);

    // random pairs; long result hold-off early on, no idling near the end
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 100) hold_long = 1'b1;
      if (n == NumRandom - 150) calm = 1'b1;
      lat1 = pick_lat();
      lon1 = $urandom();
      case ($urandom_range(0, 4))
        0: begin lat2 = lat1; lon2 = lon1 + $urandom_range(0, 2) - 1; end
        1: begin lat2 = lat1 + $urandom_range(0, 64) - 32; lon2 = lon1; end
        default: begin lat2 = pick_lat(); lon2 = $urandom(); end
      endcase
      send_pair(lat1, lon1, lat2, lon2);
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("ran %0d position pairs, %0d bearings checked, incl. poles,",
             sent, board.checked);
    $display("coincident points, longitude wrap and a long output stall");
    if (board.errors == 0 && board.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ----- great_circle_bearing.f -----
hw/rtl/gcb_pkg.sv
hw/rtl/great_circle_bearing.sv
hw/rtl/gcb_checker.sv
tb/great_circle_bearing_test.sv
